/* rtl/ilc_pkg.sv */
// ----------------------------------------------------------------------------
// Integrated Legendre coefficient package
// Shared constants, types and the controller state encoding.
// ----------------------------------------------------------------------------
package ilc_pkg;

	localparam int DEF_MAX_DEGREE    = 16;
	localparam int DEF_FRACTION_BITS = 32;
	localparam int COEF_W            = 56;
	localparam int DEG_W             = 5;
	localparam int NUM_W             = 64;

	typedef logic signed [COEF_W-1:0] coef_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_RD,
		ST_WAIT,
		ST_MUL,
		ST_DIV,
		ST_WR,
		ST_SWAP,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic       init;
		logic       rd;
		logic       mul;
		logic       div_start;
		logic       wr;
		logic       swap;
		logic       out_rd;
		logic       out_bef;
		logic [5:0] n;
		logic [5:0] i;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

/* rtl/ilc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ilc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Storage and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/ilc_ctrl.sv */
// ----------------------------------------------------------------------------
// Integrated Legendre controller
// Sequences row initialization, the recurrence and the coefficient output.
// ----------------------------------------------------------------------------
module ilc_ctrl import ilc_pkg::*; #(
	parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [DEG_W-1:0] degree,
	input  logic             out_free,
	output logic             out_push,
	output logic             out_last,
	output logic [DEG_W-1:0] out_index,
	output cmd_t             cmd,
	input  sts_t             sts
);
	state_t state_q, state_d;
	logic [5:0] k_q, n_q, i_q;
	logic [5:0] k_d, n_d, i_d;
	logic [5:0] deg_sat;

	assign deg_sat = (6'(degree) > 6'(MAX_DEGREE)) ? 6'(MAX_DEGREE) : 6'(degree);

	// Next state and counters.
	always_comb begin
		state_d = state_q;
		k_d = k_q;
		n_d = n_q;
		i_d = i_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					k_d = deg_sat;
					i_d = '0;
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				if (i_q == 6'(MAX_DEGREE)) begin
					n_d = 6'd2;
					i_d = '0;
					state_d = (k_q >= 6'd2) ? ST_RD : ST_OUT_RD;
				end else begin
					i_d = i_q + 6'd1;
				end
			end
			ST_RD:   state_d = ST_WAIT;
			ST_WAIT: state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (sts.div_done) state_d = ST_WR;
			ST_WR: begin
				if (i_q == n_q) begin
					i_d = '0;
					state_d = ST_SWAP;
				end else begin
					i_d = i_q + 6'd1;
					state_d = ST_RD;
				end
			end
			ST_SWAP: begin
				if (n_q == k_q) begin
					state_d = ST_OUT_RD;
				end else begin
					n_d = n_q + 6'd1;
					state_d = ST_RD;
				end
			end
			ST_OUT_RD:   state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					if (i_q == k_q) begin
						state_d = ST_IDLE;
					end else begin
						i_d = i_q + 6'd1;
						state_d = ST_OUT_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and commands; degree zero is read from the older row.
	always_comb begin
		cmd = '0;
		cmd.n = n_q;
		cmd.i = i_q;
		cmd.out_bef = (k_q == 6'd0);
		in_ready = 1'b0;
		out_push = 1'b0;
		out_last = (i_q == k_q);
		out_index = i_q[DEG_W-1:0];
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_INIT:   cmd.init = 1'b1;
			ST_RD:     cmd.rd = 1'b1;
			ST_MUL: begin
				cmd.mul = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_WR:     cmd.wr = 1'b1;
			ST_SWAP:   cmd.swap = 1'b1;
			ST_OUT_RD: cmd.out_rd = 1'b1;
			ST_OUT_WAIT: cmd.out_rd = 1'b1;
			ST_OUT: begin
				cmd.out_rd = 1'b1;
				out_push = out_free;
			end
			default: ;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			n_q <= '0;
			i_q <= '0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
			n_q <= n_d;
			i_q <= i_d;
		end
	end
endmodule

/* rtl/ilc_datapath.sv */
// ----------------------------------------------------------------------------
// Integrated Legendre datapath
// Three row memories with rotating bank pointers, one multiply-subtract, serial divider.
// ----------------------------------------------------------------------------
module ilc_datapath import ilc_pkg::*; #(
	parameter int MAX_DEGREE    = DEF_MAX_DEGREE,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	output sts_t  sts,
	output coef_t rd_coef
);
	localparam int DEPTH = MAX_DEGREE + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam logic signed [COEF_W-1:0] ONE = COEF_W'(1) <<< FRACTION_BITS;
	localparam logic signed [COEF_W-1:0] CMAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] CMIN = {1'b1, {(COEF_W-1){1'b0}}};

	// Three banks rotate: prev, before, fresh.
	logic [1:0] prev_q, bef_q, frs_q;
	logic [2:0] we;
	logic [AW-1:0] waddr [3];
	logic [AW-1:0] raddr [3];
	coef_t wdata [3];
	coef_t rdata [3];
	coef_t res_q;
	logic hi_ok_q, lo_ok_q;

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_bank
			ilc_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_ram (
				.clk(clk), .we(we[g]), .waddr(waddr[g]), .wdata(wdata[g]),
				.raddr(raddr[g]), .rdata(rdata[g])
			);
		end
	endgenerate

	// Write and read address steering.
	always_comb begin
		for (int b = 0; b < 3; b++) begin
			we[b] = 1'b0;
			waddr[b] = cmd.i[AW-1:0];
			wdata[b] = res_q;
			raddr[b] = cmd.i[AW-1:0];
			if (cmd.init) begin
				we[b] = (2'(b) != frs_q);
				if (2'(b) == bef_q) begin
					wdata[b] = (cmd.i == 6'd0) ? -ONE : '0;
				end else begin
					wdata[b] = (cmd.i == 6'd1) ? ONE : '0;
				end
			end else if (cmd.wr) begin
				we[b] = (2'(b) == frs_q);
			end
			if (2'(b) == prev_q && !cmd.out_rd) begin
				raddr[b] = cmd.i[AW-1:0] - AW'(1);
			end
		end
	end

	// Degree zero answers from the older row, all others from the newest.
	assign rd_coef = cmd.out_bef ? rdata[bef_q] : rdata[prev_q];

	// Operand gating: out-of-range entries count as zero.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			hi_ok_q <= (cmd.i >= 6'd1);
			lo_ok_q <= (cmd.i + 6'd2 <= cmd.n);
		end
	end

	// Multiply-subtract into the numerator.
	logic signed [NUM_W-1:0] num_q;
	logic signed [7:0] cb, cc;
	logic signed [NUM_W-1:0] pb, pc;
	assign cb = 8'(2 * cmd.n) - 8'sd3;
	assign cc = 8'(cmd.n) - 8'sd3;
	assign pb = hi_ok_q ? NUM_W'(rdata[prev_q]) * NUM_W'(cb) : '0;
	assign pc = lo_ok_q ? NUM_W'(rdata[bef_q]) * NUM_W'(cc) : '0;

	// Restoring divider state: magnitude divided by n, one bit a cycle.
	localparam int CW = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] quo_q;
	logic [6:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;
	logic [7:0] rtry;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			num_q <= pb - pc;
		end
	end

	assign rtry = {rem_q, quo_q[NUM_W-1]};

	// Divider sequence: loaded in the cycle after the multiply.
	logic ld_q, done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ld_q <= cmd.div_start;
			done_q <= 1'b0;
			if (cnt_q == CW'(1)) done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
			quo_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (ld_q) begin
			neg_q <= num_q[NUM_W-1];
			quo_q <= num_q[NUM_W-1] ? -num_q : num_q;
			rem_q <= '0;
			cnt_q <= CW'(NUM_W);
		end else if (cnt_q != '0) begin
			if (rtry >= 8'(cmd.n)) begin
				rem_q <= 7'(rtry - 8'(cmd.n));
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rtry[6:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign sts.div_done = done_q;

	// Rounding, sign and saturation.
	logic [NUM_W:0] mag;
	logic signed [NUM_W+1:0] sval;
	always_comb begin
		mag = {1'b0, quo_q} + ((8'({rem_q, 1'b0}) >= 8'(cmd.n)) ? 65'd1 : 65'd0);
		sval = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	always_ff @(posedge clk) begin
		if (done_q) begin
			if (sval > $signed((NUM_W+2)'(CMAX))) res_q <= CMAX;
			else if (sval < (NUM_W+2)'(CMIN)) res_q <= CMIN;
			else res_q <= sval[COEF_W-1:0];
		end
	end

	// Bank rotation: fresh becomes prev, prev becomes before.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 2'd0;
			bef_q <= 2'd1;
			frs_q <= 2'd2;
		end else if (cmd.swap) begin
			prev_q <= frs_q;
			bef_q <= prev_q;
			frs_q <= bef_q;
		end
	end
endmodule

/* rtl/integrated_legendre_coefficients_core.sv */
// Sequence: row set-up over entries 0 to MAX_DEGREE, then per coefficient of
// degree n a read, a multiply-subtract and a 64-step serial divide, then the outputs.
// Throughput: one degree request at a time; for k >= 2 the recurrence runs
// rows 2 to k, and the serial divider by n dominates its run time.
// Reset: arst_n clears the controller and output stage; rows are rebuilt per run.
// ----------------------------------------------------------------------------
// Integrated Legendre coefficient core
// Emits the monomial coefficients of the integrated Legendre polynomial L_k.
// ----------------------------------------------------------------------------
module integrated_legendre_coefficients_core import ilc_pkg::*; #(
	parameter int MAX_DEGREE    = DEF_MAX_DEGREE,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [4:0] degree
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [4:0] power_index, [60:5] coefficient
	output logic        m_tlast   // last_coefficient
);
	cmd_t cmd;
	sts_t sts;
	coef_t rd_coef;
	logic out_push, out_last, out_free;
	logic [DEG_W-1:0] out_index;

	ilc_ctrl #(.MAX_DEGREE(MAX_DEGREE)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.degree(s_tdata[DEG_W-1:0]), .out_free(out_free), .out_push(out_push),
		.out_last(out_last), .out_index(out_index), .cmd(cmd), .sts(sts)
	);

	ilc_datapath #(.MAX_DEGREE(MAX_DEGREE), .FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .rd_coef(rd_coef)
	);

	assign out_free = !m_tvalid || m_tready;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= out_push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && out_push) begin
			m_tdata <= {3'b000, rd_coef, out_index};
			m_tlast <= out_last;
		end
	end
endmodule

/* tb/sv/integrated_legendre_coefficients_core_tb.sv */
// ----------------------------------------------------------------------------
// Integrated Legendre coefficient core testbench
// Sends degree requests over the input stream and checks every emitted
// coefficient against a fixed-point recurrence computed here, with random
// gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module integrated_legendre_coefficients_core_tb;
	import ilc_pkg::*;

	localparam int MAXD      = DEF_MAX_DEGREE;
	localparam int FRAC      = DEF_FRACTION_BITS;
	localparam int WDOG_MAX  = 200000;

	typedef struct packed {
		logic [4:0] power;
		coef_t      coef;
		logic       last;
	} coef_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;

	logic [4:0]  degree_queue[$];
	coef_item_t  expected_coefs[$];
	int          errors = 0;
	int          degrees_sent = 0;
	int          coefs_seen = 0;
	int          idle_cycles = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	bit          hold_send = 1'b0;

	integrated_legendre_coefficients_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	// Saturate a wide value to the 56-bit signed coefficient range.
	function automatic longint sat_coef(longint v);
		longint hi;
		hi = (64'sd1 <<< 55) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// Divide by positive n, rounding to nearest with ties away from zero.
	function automatic longint round_div(longint num, longint n);
		longint q, r;
		q = num / n;
		r = num % n;
		if (r < 0) r = -r;
		if (2 * r >= n) q += (num < 0) ? -1 : 1;
		return q;
	endfunction

	// Build L_k by the two-row recurrence and queue its coefficients.
	task automatic predict_legendre(input logic [4:0] degree);
		longint prev_row[MAXD+1];
		longint older_row[MAXD+1];
		longint next_row[MAXD+1];
		longint hi, lo;
		int k;
		coef_item_t it;
		k = (degree > MAXD) ? MAXD : degree;
		foreach (prev_row[i]) begin
			prev_row[i] = 0;
			older_row[i] = 0;
		end
		older_row[0] = -(64'sd1 <<< FRAC);
		prev_row[1] = 64'sd1 <<< FRAC;
		for (int n = 2; n <= k; n++) begin
			for (int i = 0; i <= MAXD; i++) begin
				next_row[i] = 0;
				if (i <= n) begin
					hi = (i >= 1) ? prev_row[i-1] : 0;
					lo = (i + 2 <= n) ? older_row[i] : 0;
					next_row[i] = sat_coef(round_div((2*n-3) * hi - (n-3) * lo, n));
				end
			end
			older_row = prev_row;
			prev_row = next_row;
		end
		for (int i = 0; i <= k; i++) begin
			it.power = i[4:0];
			it.coef = (k == 0) ? older_row[i][55:0] : prev_row[i][55:0];
			it.last = (i == k);
			expected_coefs = {expected_coefs, it};
		end
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Driver: offers queued degrees and predicts each accepted one.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_legendre(s_tdata[4:0]);
			degrees_sent++;
		end
		if (!(s_tvalid && !s_tready)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (arst_n && !hold_send && degree_queue.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= {3'b000, degree_queue.pop_front()};
				gap_left <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: checks each coefficient and applies random output stalls.
	always @(posedge clk) begin
		coef_item_t want;
		if (m_tvalid && m_tready) begin
			coefs_seen++;
			if (expected_coefs.size() == 0) begin
				$display("%0t: unexpected coefficient, actual power=%0d coef=%0d last=%0b",
					$time, m_tdata[4:0], $signed(m_tdata[60:5]), m_tlast);
				errors++;
			end else begin
				want = expected_coefs.pop_front();
				if (m_tdata[4:0] !== want.power) begin
					$display("%0t: power mismatch, expected %0d actual %0d",
						$time, want.power, m_tdata[4:0]);
					errors++;
				end
				if (m_tdata[60:5] !== want.coef) begin
					$display("%0t: coefficient mismatch at power %0d, expected %0d actual %0d",
						$time, want.power, want.coef, $signed(m_tdata[60:5]));
					errors++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last flag mismatch at power %0d, expected %0b actual %0b",
						$time, want.power, want.last, m_tlast);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
			stall_left <= pick_gap();
		end
	end

	// Watchdog: counts cycles with no accepted item on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("%0t: watchdog expired with %0d coefficients outstanding",
				$time, expected_coefs.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int total;
		// Directed: every degree in range, and degrees above the maximum.
		for (int d = 0; d <= 16; d++) degree_queue = {degree_queue, d[4:0]};
		degree_queue = {degree_queue, 5'd31};
		degree_queue = {degree_queue, 5'd17};
		degree_queue = {degree_queue, 5'd21};
		degree_queue = {degree_queue, 5'd10};
		degree_queue = {degree_queue, 5'd0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (degree_queue.size() == 0);
		// Let the whole directed set drain before continuing.
		@(posedge clk) hold_send <= 1'b1;
		wait (!s_tvalid && expected_coefs.size() == 0);
		@(posedge clk);
		// Random: most degrees small to keep the run short, some from the full 5-bit range.
		for (int n = 0; n < 140; n++) begin
			if ($urandom_range(0, 9) == 0)
				degree_queue = {degree_queue, 5'($urandom_range(0, 31))};
			else
				degree_queue = {degree_queue, 5'($urandom_range(0, 6))};
		end
		hold_send <= 1'b0;
		wait (degree_queue.size() == 0 && !s_tvalid);
		wait (expected_coefs.size() == 0);
		repeat (100) @(posedge clk);
		total = degrees_sent;
		$display("Sent %0d degree requests and checked %0d coefficients,", total, coefs_seen);
		$display("covering degrees 0 to 31 with random gaps and output stalls.");
		if (errors == 0 && expected_coefs.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/ilc_pkg.sv
rtl/ilc_ram.sv
rtl/ilc_ctrl.sv
rtl/ilc_datapath.sv
rtl/integrated_legendre_coefficients_core.sv
tb/sv/integrated_legendre_coefficients_core_tb.sv
